FILE: rtl/sha256_digest_core_assert.svh
// assertion macros for the digest core
`ifndef SHA256_DIGEST_CORE_ASSERT_SVH
`define SHA256_DIGEST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the digest core
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;

    typedef logic [31:0] t_word;

    // byte source selection for the buffer write
    typedef enum logic [1:0] {
        SRC_MSG = 2'd0,
        SRC_PAD = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN = 2'd3
    } t_src;

    // controller to datapath commands
    typedef struct packed {
        logic       push;      // write one byte into the block buffer
        t_src       src;
        logic [2:0] len_idx;   // length byte index, msb first
        logic       add_len;   // count a message byte
        logic       start;     // load work vars from chain
        logic       round;     // run one round
        logic       finish;    // fold work vars into chain
        logic       clear;     // back to initial hash, zero length
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_sts;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word round_k(input logic [5:0] i);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[i];
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h [8] = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        init_h = h[i];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// block buffer, message schedule, round unit and chaining state
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_digest_core_assert.svh"
module sha_datapath
    import sha_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire [7:0]  i_byte,
    input  wire [2:0]  i_rd_idx,
    output t_sts       o_sts,
    output t_word      o_hash
);
    t_word       r_w [16];
    t_word       r_v [8];
    t_word       r_h [8];
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic [7:0]  wr_byte;
    t_word       w15, w2, w_new, w_cur, t1, t2;

    assign o_sts.fill = r_fill;
    assign o_hash = r_h[i_rd_idx];

    // byte source for the buffer
    always_comb begin
        case (i_cmd.src)
            SRC_MSG:  wr_byte = i_byte;
            SRC_PAD:  wr_byte = PadByte;
            SRC_ZERO: wr_byte = 8'h00;
            SRC_LEN:  wr_byte = r_len[8*(7-i_cmd.len_idx) +: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    // schedule and round logic
    always_comb begin
        w15 = r_w[1];
        w2 = r_w[14];
        w_new = r_w[0] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + r_w[9]
              + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        w_cur = r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // schedule window holds the block big-endian while filling,
    // then shifts one word per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (i_cmd.round) begin
            for (int t = 0; t < 15; t++) begin
                r_w[t] <= r_w[t+1];
            end
            r_w[15] <= w_new;
        end
    end

    // control-bearing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len <= '0;
            r_rnd <= '0;
            for (int t = 0; t < 8; t++) begin
                r_h[t] <= init_h(3'(t));
                r_v[t] <= '0;
            end
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.add_len) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.start) begin
                r_rnd <= '0;
                for (int t = 0; t < 8; t++) begin
                    r_v[t] <= r_h[t];
                end
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 6'd1;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.finish) begin
                for (int t = 0; t < 8; t++) begin
                    r_h[t] <= r_h[t] + r_v[t];
                end
            end
            if (i_cmd.clear) begin
                r_len <= '0;
                for (int t = 0; t < 8; t++) begin
                    r_h[t] <= init_h(3'(t));
                end
            end
        end
    end

    `SHA_ASSERT_IMP(a_no_push_in_rounds, i_clk, i_rst_n, i_cmd.round, !i_cmd.push)
    `SHA_ASSERT_NXT(a_start_rnd0, i_clk, i_rst_n, i_cmd.start, r_rnd == 6'd0)
    `SHA_ASSERT_NXT(a_clear_len, i_clk, i_rst_n, i_cmd.clear, r_len == 64'd0)
endmodule
`default_nettype wire

FILE: rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer for byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_digest_core_assert.svh"
module sha_ctrl
    import sha_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_present,
    input  wire        i_eom,
    output logic       o_in_ready,
    input  wire        i_out_ready,
    output logic       o_out_valid,
    output logic [2:0] o_idx,
    input  wire t_sts  i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ZERO, S_LEN, S_START, S_ROUND, S_FINISH, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;     // in compression: 1 while the pad byte is still due
    logic       r_pad, n_pad;     // padding in progress for this block
    logic [2:0] r_idx, n_idx;
    logic [5:0] r_rcnt;           // round counter
    logic       r_len_done, n_len_done;
    t_state     ret_state;
    logic       acc;
    logic       last_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_idx = r_idx;
    assign acc = i_in_valid && o_in_ready;
    assign last_acc = o_out_valid && i_out_ready && (r_idx == 3'd7);

    // where to go once a compression ends
    always_comb begin
        if (!r_pad) begin
            ret_state = S_IDLE;
        end else if (r_len_done) begin
            ret_state = S_OUT;
        end else if (r_cnt == 6'd1) begin
            // the last message byte filled the block, pad byte goes next
            ret_state = S_PAD;
        end else begin
            ret_state = S_ZERO;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pad = r_pad;
        n_idx = r_idx;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.push = i_present;
                    o_cmd.add_len = i_present;
                    o_cmd.src = SRC_MSG;
                    if (i_present && i_sts.fill == 6'd63) begin
                        n_pad = i_eom;
                        n_cnt = 6'd1;
                        n_state = S_START;
                    end else if (i_eom) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.push = 1'b1;
                o_cmd.src = SRC_PAD;
                n_pad = 1'b1;
                n_cnt = 6'd0;
                n_state = (i_sts.fill == 6'd63) ? S_START : S_ZERO;
            end
            S_ZERO: begin
                if (i_sts.fill == LenPos) begin
                    n_cnt = 6'd0;
                    n_state = S_LEN;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_ZERO;
                    if (i_sts.fill == 6'd63) begin
                        n_state = S_START;
                    end
                end
            end
            S_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.src = SRC_LEN;
                o_cmd.len_idx = r_cnt[2:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd7) begin
                    n_cnt = 6'd0;
                    n_idx = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = (r_rcnt == 6'd63) ? S_FINISH : S_ROUND;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ret_state;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.clear = 1'b1;
                        n_pad = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // length field written, the next compression is the last one
    always_comb begin
        n_len_done = r_len_done;
        if (r_state == S_LEN && r_cnt == 6'd7) begin
            n_len_done = 1'b1;
        end else if (r_state == S_OUT) begin
            n_len_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pad <= 1'b0;
            r_idx <= '0;
            r_rcnt <= '0;
            r_len_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pad <= n_pad;
            r_idx <= n_idx;
            r_len_done <= n_len_done;
            if (r_state == S_START) begin
                r_rcnt <= '0;
            end else if (r_state == S_ROUND) begin
                r_rcnt <= r_rcnt + 6'd1;
            end
        end
    end

    `SHA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `SHA_ASSERT_NXT(a_last_leaves, i_clk, i_rst_n, last_acc, r_state == S_IDLE)
    `SHA_ASSERT_NXT(a_start_rounds, i_clk, i_rst_n, r_state == S_START, r_state == S_ROUND)
endmodule
`default_nettype wire

FILE: rtl/sha256_digest_core.sv
// ----------------------------------------------------------------------------
// sha256_digest_core
// byte-stream SHA-256 with padding and eight-word digest output
//
//   channel  dir  tdata                          tuser
//   s_axis   in   msg_byte[7:0]                  byte_present, end_of_message
//   m_axis   out  digest_word[31:0]              word_index[2:0]     tlast=last
//
// each message byte goes into the block buffer; every 64th byte starts the
// 64-round compression unit (start, 64 rounds, chain update).
// an end marker adds the padding bytes, a non-writing step on reaching the
// length field, and one or two compressions, then eight output words.
// input is stalled during compression, padding and digest output.
// reset is synchronous; chaining state returns to the initial hash.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_digest_core
    import sha_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // msg_byte
    input  wire  [1:0]  s_axis_tuser,   // byte_present, end_of_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast
);
    t_cmd cmd;
    t_sts sts;
    logic [2:0] idx;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_present(s_axis_tuser[0]),
        .i_eom(s_axis_tuser[1]), .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_idx(idx), .i_sts(sts), .o_cmd(cmd)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_byte(s_axis_tdata), .i_rd_idx(idx), .o_sts(sts), .o_hash(m_axis_tdata)
    );

    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 3'd7);
endmodule
`default_nettype wire

FILE: verif/sha256_digest_core_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_core_checker
// watches the byte and digest channels, hashes each message on its own and
// compares every digest word with the oldest expected one
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_digest_core_checker
    import sha_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // msg_byte
    input  wire  [1:0]  s_axis_tuser,   // byte_present, end_of_message
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,   // digest_word
    input  wire  [2:0]  m_axis_tuser,   // word_index
    input  wire         m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  hash_st [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    t_digest_word digest_q [$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = digest_q.size();

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the buffered block
    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        v = hash_st;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                s0 = ror(w[(t-15)&15], 7) ^ ror(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
                s1 = ror(w[(t-2)&15], 17) ^ ror(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
                wt = w[t&15] + s0 + w[(t-7)&15] + s1;
                w[t&15] = wt;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + wt;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_st[i] += v[i];
    endtask

    task automatic append(logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
    endtask

    // one accepted word of the byte stream
    task automatic absorb(logic [7:0] b, logic present, logic eom);
        logic [63:0]  len;
        t_digest_word d;
        if (present) begin
            append(b);
            msg_bits += 64'd8;
        end
        if (eom) begin
            len = msg_bits;
            append(PadByte);
            while (fill != 56)
                append(8'h00);
            for (int i = 0; i < 8; i++)
                append(len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                d.word = hash_st[i];
                d.idx  = 3'(i);
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            hash_st  = IV;
            fill     = 0;
            msg_bits = '0;
        end
    endtask

    initial begin
        hash_st  = IV;
        fill     = 0;
        msg_bits = '0;
        fails    = 0;
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                absorb(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
            // digest words against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", m_axis_tdata);
                    fails++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (m_axis_tdata !== exp_w.word) begin
                        $error("digest_word expected %h actual %h", exp_w.word, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tuser !== exp_w.idx) begin
                        $error("word_index expected %0d actual %0d", exp_w.idx, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tlast !== exp_w.last) begin
                        $error("last_word expected %0d actual %0d", exp_w.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: verif/sha256_digest_core_tb.sv
// ----------------------------------------------------------------------------
// sha256_digest_core_tb
// feeds byte-stream messages of many lengths with random gaps and stalls;
// the checker hashes each message independently and compares the digests
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_digest_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // msg_byte
    logic [1:0]  s_axis_tuser = '0;   // byte_present, end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // digest_word
    logic [2:0]  m_axis_tuser;        // word_index
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          out_wait = 0;

    always #6 i_clk = ~i_clk;

    sha256_digest_core u_dut (.*);

    sha256_digest_core_checker u_chk (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // sends one word and waits for its handshake
    task automatic send_word(logic [7:0] b, logic present, logic eom);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {eom, present};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // a message of len bytes; the end marker rides on the last byte or stands bare
    task automatic send_message(int len, bit bare_end, int fill_mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill_mode)
                0:       b = 8'($urandom);
                1:       b = 8'h00;
                default: b = 8'hff;
            endcase
            send_word(b, 1'b1, (!bare_end && i == len - 1));
        end
        if (bare_end || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver waits a random number of cycles before each digest word
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            w = $urandom_range(0, 6);
            out_wait <= w;
            m_axis_tready <= (w == 0);
        end else if (m_axis_tvalid && m_axis_tready) begin
            w = $urandom_range(0, 6);
            out_wait <= w;
            m_axis_tready <= (w == 0);
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            m_axis_tready <= (out_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("sha256_digest_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int sent;
        int len;
        bit bare;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, single bytes at the extremes, an ignored word, a short message
        send_message(0, 1'b1, 0);
        send_message(1, 1'b0, 1);
        send_message(1, 1'b1, 2);
        send_word(8'h5a, 1'b0, 1'b0);    // neither byte nor end: ignored
        send_message(3, 1'b0, 0);
        // random: mostly short messages, a few across padding and block edges
        sent = 8;
        while (sent < 360) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(54, 57);
                1:       len = $urandom_range(62, 66);
                2:       len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                send_word(8'($urandom), 1'b0, 1'b0);
                sent += 1;
            end
            bare = ($urandom_range(0, 2) == 0);
            send_message(len, bare, $urandom_range(0, 9) == 0 ? 2 : 0);
            sent += len + ((bare || len == 0) ? 1 : 0);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("sha256_digest_core_tb OK");
        else
            $display("sha256_digest_core_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
